### hdl/ascii_coordinate_frame_parser_core_defines.svh
// Assertion macros for the coordinate frame parser.
`ifndef ASCII_COORDINATE_FRAME_PARSER_CORE_DEFINES_SVH
`define ASCII_COORDINATE_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ACFP_ASSERT_IMP(lbl, clk_s, rstn_s, ant, con) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ant) |-> (con)) \
    else $error("acfp assertion failed");

// Next-cycle implication, disabled during reset.
`define ACFP_ASSERT_NXT(lbl, clk_s, rstn_s, ant, con) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ant) |=> (con)) \
    else $error("acfp assertion failed");

`endif

### hdl/acfp_pkg.sv
// Package: types, character codes and helpers for the coordinate frame parser.
package acfp_pkg;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_t;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [31:0] frames_seen;
    logic        frame_done;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0] d;
    d = b - CH_ZERO;
    return (acc * 16'd10) + {8'd0, d};
  endfunction

endpackage

### hdl/ascii_coordinate_frame_parser_core.sv
// Top level of the ASCII coordinate frame parser.
//
//   channel | direction | payload                                      | handshake
//   in_     | input     | rx_byte[7:0]                                 | in_valid/in_ready
//   out_    | output    | coord_x, coord_y, frames_seen, frame_done    | out_valid/out_ready
//
// One byte per cycle while out_ready is high; out_valid follows input and result registers.
// Throughput is set by the single parse stage between input and result registers.
// Synchronous active-low reset clears the frame state, counter and both valid flags.
// A stalled output holds the parse stage; input stays ready while the stage can drain.
`include "ascii_coordinate_frame_parser_core_defines.svh"
module ascii_coordinate_frame_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_coord_x,
  output logic [15:0] out_coord_y,
  output logic [31:0] out_frames_seen,
  output logic        out_frame_done
);

  acfp_pkg::in_item_t item;
  acfp_pkg::result_t  res;
  logic               out_free;
  logic               step;

  assign step = item.valid && out_free;

  acfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .in_ready   (in_ready),
    .item       (item)
  );

  acfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (item.rx_byte),
    .res     (res)
  );

  acfp_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step),
    .res             (res),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .free            (out_free),
    .out_coord_x     (out_coord_x),
    .out_coord_y     (out_coord_y),
    .out_frames_seen (out_frames_seen),
    .out_frame_done  (out_frame_done)
  );

  `ACFP_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !out_valid, in_ready)
  `ACFP_ASSERT_NXT(a_step_fills_out, clk, rst_n, step, out_valid)
  `ACFP_ASSERT_NXT(a_stage_holds, clk, rst_n, item.valid && !step, item.valid)
  `ACFP_ASSERT_NXT(a_done_counts, clk, rst_n, step && res.frame_done,
                   out_frame_done && (out_frames_seen == $past(res.frames_seen)))

endmodule

### hdl/acfp_in_reg.sv
// Input register stage holding one received byte.
module acfp_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_rx_byte,
  input  logic               take,
  output logic               in_ready,
  output acfp_pkg::in_item_t item
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

### hdl/acfp_parser.sv
// Frame state machine with digit accumulators, latched coordinates and frame count.
module acfp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output acfp_pkg::result_t res
);

  acfp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] acc_x_r, acc_x_nxt;
  logic [15:0] acc_y_r, acc_y_nxt;
  logic [15:0] lat_x_r, lat_x_nxt;
  logic [15:0] lat_y_r, lat_y_nxt;
  logic [31:0] total_r, total_nxt;
  logic        done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= acfp_pkg::PH_WAIT;
      acc_x_r <= '0;
      acc_y_r <= '0;
      lat_x_r <= '0;
      lat_y_r <= '0;
      total_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      lat_x_r <= lat_x_nxt;
      lat_y_r <= lat_y_nxt;
      total_r <= total_nxt;
    end
  end

  always_comb begin
    phase_nxt = acfp_pkg::PH_WAIT;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    lat_x_nxt = lat_x_r;
    lat_y_nxt = lat_y_r;
    total_nxt = total_r;
    done      = 1'b0;
    case (phase_r)
      acfp_pkg::PH_X: begin
        if (acfp_pkg::is_digit(rx_byte)) begin
          acc_x_nxt = acfp_pkg::acc_digit(acc_x_r, rx_byte);
          phase_nxt = acfp_pkg::PH_X;
        end else if (rx_byte == acfp_pkg::CH_COMMA) begin
          acc_y_nxt = '0;
          phase_nxt = acfp_pkg::PH_Y;
        end
      end
      acfp_pkg::PH_Y: begin
        if (acfp_pkg::is_digit(rx_byte)) begin
          acc_y_nxt = acfp_pkg::acc_digit(acc_y_r, rx_byte);
          phase_nxt = acfp_pkg::PH_Y;
        end else if (rx_byte == acfp_pkg::CH_HASH) begin
          lat_x_nxt = acc_x_r;
          lat_y_nxt = acc_y_r;
          total_nxt = total_r + 32'd1;
          done      = 1'b1;
        end
      end
      default: begin
        if (rx_byte == acfp_pkg::CH_AT) begin
          acc_x_nxt = '0;
          phase_nxt = acfp_pkg::PH_X;
        end
      end
    endcase
  end

  assign res.coord_x     = lat_x_nxt;
  assign res.coord_y     = lat_y_nxt;
  assign res.frames_seen = total_nxt;
  assign res.frame_done  = done;

endmodule

### hdl/acfp_out_reg.sv
// Result register driving the output channel.
module acfp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  acfp_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              free,
  output logic [15:0]       out_coord_x,
  output logic [15:0]       out_coord_y,
  output logic [31:0]       out_frames_seen,
  output logic              out_frame_done
);

  logic              valid_r, valid_nxt;
  acfp_pkg::result_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_coord_x     = res_r.coord_x;
  assign out_coord_y     = res_r.coord_y;
  assign out_frames_seen = res_r.frames_seen;
  assign out_frame_done  = res_r.frame_done;

endmodule
